>>> src/bgh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgh_pkg: shared types and constants of the tiled gray histogram
// Grid geometry, field widths, luma coefficients and index helpers.
// ----------------------------------------------------------------------------
package bgh_pkg;

    localparam int GRID_ROWS    = 10;
    localparam int GRID_COLS    = 10;
    localparam int BINS         = 16;
    localparam int NUM_COUNTERS = GRID_ROWS * GRID_COLS * BINS;

    localparam int ROW_W   = $clog2(GRID_ROWS + 1);
    localparam int COL_W   = $clog2(GRID_COLS + 1);
    localparam int BIN_W   = $clog2(BINS);
    localparam int IDX_W   = $clog2(NUM_COUNTERS);
    localparam int BIN_DIV = 256 / BINS;

    localparam int COUNT_W = 18;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam int IMG_W = 12;
    localparam int BLK_W = 9;

    // luma weights, Q14
    localparam int SUM_W = 22;
    localparam logic [SUM_W-1:0] COEF_B = SUM_W'(1868);
    localparam logic [SUM_W-1:0] COEF_G = SUM_W'(9617);
    localparam logic [SUM_W-1:0] COEF_R = SUM_W'(4899);
    localparam logic [SUM_W-1:0] ROUND  = SUM_W'(8192);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_HEIGHT = 2'd2;

    localparam logic [IMG_W-1:0] RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [BLK_W-1:0] RST_BLOCK_WIDTH  = 9'd64;
    localparam logic [BLK_W-1:0] RST_BLOCK_HEIGHT = 9'd48;

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    typedef struct packed {
        logic [IMG_W-1:0] image_width;
        logic [BLK_W-1:0] block_width;
        logic [BLK_W-1:0] block_height;
    } t_geom;

    typedef struct packed {
        logic [ROW_W-1:0] grid_row;
        logic [COL_W-1:0] grid_col;
        logic             in_grid;
    } t_pos;

    function automatic logic [BIN_W-1:0] luma_bin(input logic [7:0] gray);
        int q;
        q = int'(gray) / BIN_DIV;
        if (q > BINS - 1) q = BINS - 1;
        return BIN_W'(q);
    endfunction

    function automatic logic [IDX_W-1:0] counter_index(
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col,
        input logic [BIN_W-1:0] bin
    );
        return (IDX_W'(row) * IDX_W'(GRID_COLS) + IDX_W'(col)) * IDX_W'(BINS) + IDX_W'(bin);
    endfunction

endpackage

>>> src/bgh_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgh_if: stream and register channels of the tiled gray histogram
// Input items, result beats and register writes, each valid/ready.
// ----------------------------------------------------------------------------
interface bgh_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [3:0] read_block_row;
    logic [3:0] read_block_col;
    logic [3:0] read_bin;

    modport source (
        output valid, kind, blue, green, red, read_block_row, read_block_col, read_bin,
        input  ready
    );
    modport sink (
        input  valid, kind, blue, green, red, read_block_row, read_block_col, read_bin,
        output ready
    );
endinterface

interface bgh_out_if;
    logic                         valid;
    logic                         ready;
    logic [bgh_pkg::COUNT_W-1:0]  count;

    modport source (output valid, count, input ready);
    modport sink   (input valid, count, output ready);
endinterface

interface bgh_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bgh_pkg::CFG_IDX_W-1:0]  index;
    logic [bgh_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/bgh_count_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgh_count_ram: simple dual-port counter memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bgh_count_ram #(
    parameter  int DEPTH = 1600,
    parameter  int WIDTH = 18,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/bgh_raster.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgh_raster: raster position tracker
// Follows the pixel position and maps it onto the block grid.
// ----------------------------------------------------------------------------
module bgh_raster (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  logic           i_clear,
    input  bgh_pkg::t_geom i_geom,
    output bgh_pkg::t_pos  o_pos
);

    logic [bgh_pkg::IMG_W-1:0] r_col_pos,    n_col_pos;
    logic [bgh_pkg::BLK_W-1:0] r_col_in_blk, n_col_in_blk;
    logic [bgh_pkg::COL_W-1:0] r_grid_col,   n_grid_col;
    logic [bgh_pkg::BLK_W-1:0] r_row_in_blk, n_row_in_blk;
    logic [bgh_pkg::ROW_W-1:0] r_grid_row,   n_grid_row;

    logic [bgh_pkg::IMG_W-1:0] w_iw;
    logic [bgh_pkg::BLK_W-1:0] w_bw;
    logic [bgh_pkg::BLK_W-1:0] w_bh;

    // a zero register acts as one
    assign w_iw = (i_geom.image_width  == '0) ? bgh_pkg::IMG_W'(1) : i_geom.image_width;
    assign w_bw = (i_geom.block_width  == '0) ? bgh_pkg::BLK_W'(1) : i_geom.block_width;
    assign w_bh = (i_geom.block_height == '0) ? bgh_pkg::BLK_W'(1) : i_geom.block_height;

    always_comb begin
        n_col_pos    = r_col_pos + 1'b1;
        n_col_in_blk = r_col_in_blk + 1'b1;
        n_grid_col   = r_grid_col;
        n_row_in_blk = r_row_in_blk;
        n_grid_row   = r_grid_row;
        if (n_col_in_blk >= w_bw) begin
            n_col_in_blk = '0;
            if (r_grid_col < bgh_pkg::COL_W'(bgh_pkg::GRID_COLS)) begin
                n_grid_col = r_grid_col + 1'b1;
            end
        end
        // end of line: restart the columns, step the rows
        if (n_col_pos >= w_iw) begin
            n_col_pos    = '0;
            n_col_in_blk = '0;
            n_grid_col   = '0;
            n_row_in_blk = r_row_in_blk + 1'b1;
            if (n_row_in_blk >= w_bh) begin
                n_row_in_blk = '0;
                if (r_grid_row < bgh_pkg::ROW_W'(bgh_pkg::GRID_ROWS)) begin
                    n_grid_row = r_grid_row + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_col_pos    <= '0;
            r_col_in_blk <= '0;
            r_grid_col   <= '0;
            r_row_in_blk <= '0;
            r_grid_row   <= '0;
        end else if (i_step) begin
            r_col_pos    <= n_col_pos;
            r_col_in_blk <= n_col_in_blk;
            r_grid_col   <= n_grid_col;
            r_row_in_blk <= n_row_in_blk;
            r_grid_row   <= n_grid_row;
        end
    end

    assign o_pos.grid_row = r_grid_row;
    assign o_pos.grid_col = r_grid_col;
    assign o_pos.in_grid  = (r_grid_row < bgh_pkg::ROW_W'(bgh_pkg::GRID_ROWS)) &&
                            (r_grid_col < bgh_pkg::COL_W'(bgh_pkg::GRID_COLS));

endmodule

>>> src/block_gray_histogram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_gray_histogram: 10 x 10 grid of 16-bin luma histograms
// BGR pixels in raster order are binned by luma into per-block counters.
// ----------------------------------------------------------------------------
// Channels: i_in carries items (pixel, read one counter, clear), o_out carries
// one count beat per read item, i_cfg writes image_width (0), block_width (1)
// and block_height (2); i_cfg is always ready.
// Items are taken one at a time; the counters live in one 1600 x 18 memory
// with registered read data, updated by read-modify-write.
// Pixel inside the grid: accept, then luma and memory read, then write-back.
// Pixel outside the grid: accepted with no memory access.
// Read: the memory is read at accept, then ST_RESULT loads the count beat into
// the output register once it is free of an earlier beat.
// Clear: a sweep that zeroes one counter per cycle.
// Reset clears the raster position, loads the register defaults and starts the
// same sweep; no item is accepted until it ends.
// A stalled receiver holds the result in the output register; pixels are still
// taken meanwhile, and a further read waits until the beat is taken.
// ----------------------------------------------------------------------------
module block_gray_histogram (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bgh_in_if.sink     i_in,
    bgh_out_if.source  o_out,
    bgh_cfg_if.sink    i_cfg
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SUM,
        ST_INC,
        ST_RESULT
    } t_state;

    t_state r_state;

    bgh_pkg::t_geom r_geom;
    bgh_pkg::t_pos  w_pos;

    logic [bgh_pkg::IDX_W-1:0]   r_clr_addr;
    logic [bgh_pkg::IDX_W-1:0]   r_addr;
    logic [bgh_pkg::IDX_W-1:0]   r_base;
    logic [bgh_pkg::SUM_W-1:0]   r_prod_b;
    logic [bgh_pkg::SUM_W-1:0]   r_prod_g;
    logic [bgh_pkg::SUM_W-1:0]   r_prod_r;
    logic                        r_rd_zero;
    logic                        r_out_valid;
    logic [bgh_pkg::COUNT_W-1:0] r_count;

    logic                        w_acc;
    logic                        w_rd_ok;
    logic [bgh_pkg::IDX_W-1:0]   w_rd_idx;
    logic [bgh_pkg::SUM_W-1:0]   w_sum;
    logic [bgh_pkg::IDX_W-1:0]   w_pix_idx;
    logic                        w_out_free;
    logic                        w_beat_load;

    logic                        w_we;
    logic [bgh_pkg::IDX_W-1:0]   w_waddr;
    logic [bgh_pkg::COUNT_W-1:0] w_wdata;
    logic                        w_re;
    logic [bgh_pkg::IDX_W-1:0]   w_raddr;
    logic [bgh_pkg::COUNT_W-1:0] w_rdata;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.image_width  <= bgh_pkg::RST_IMAGE_WIDTH;
            r_geom.block_width  <= bgh_pkg::RST_BLOCK_WIDTH;
            r_geom.block_height <= bgh_pkg::RST_BLOCK_HEIGHT;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                bgh_pkg::CFG_IMAGE_WIDTH: begin
                    r_geom.image_width <= i_cfg.data[bgh_pkg::IMG_W-1:0];
                end
                bgh_pkg::CFG_BLOCK_WIDTH: begin
                    r_geom.block_width <= i_cfg.data[bgh_pkg::BLK_W-1:0];
                end
                bgh_pkg::CFG_BLOCK_HEIGHT: begin
                    r_geom.block_height <= i_cfg.data[bgh_pkg::BLK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_acc       = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_beat_load = (r_state == ST_RESULT) && w_out_free;

    bgh_raster u_raster (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_acc && (i_in.kind == bgh_pkg::KIND_PIXEL)),
        .i_clear (w_acc && (i_in.kind == bgh_pkg::KIND_CLEAR)),
        .i_geom  (r_geom),
        .o_pos   (w_pos)
    );

    assign w_rd_ok  = (32'(i_in.read_block_row) < bgh_pkg::GRID_ROWS) &&
                      (32'(i_in.read_block_col) < bgh_pkg::GRID_COLS) &&
                      (32'(i_in.read_bin) < bgh_pkg::BINS);
    assign w_rd_idx = bgh_pkg::counter_index(bgh_pkg::ROW_W'(i_in.read_block_row),
                                             bgh_pkg::COL_W'(i_in.read_block_col),
                                             bgh_pkg::BIN_W'(i_in.read_bin));

    assign w_sum     = r_prod_b + r_prod_g + r_prod_r + bgh_pkg::ROUND;
    assign w_pix_idx = r_base + bgh_pkg::IDX_W'(bgh_pkg::luma_bin(w_sum[21:14]));

    // luma products and block base, captured at pixel accept
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_prod_b <= bgh_pkg::SUM_W'(i_in.blue)  * bgh_pkg::COEF_B;
            r_prod_g <= bgh_pkg::SUM_W'(i_in.green) * bgh_pkg::COEF_G;
            r_prod_r <= bgh_pkg::SUM_W'(i_in.red)   * bgh_pkg::COEF_R;
            r_base   <= bgh_pkg::counter_index(w_pos.grid_row, w_pos.grid_col, '0);
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = (w_rdata == bgh_pkg::COUNT_MAX) ? w_rdata : w_rdata + 1'b1;
        w_re    = 1'b0;
        w_raddr = w_rd_idx;
        case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                w_wdata = '0;
            end
            ST_IDLE: begin
                w_re = w_acc && (i_in.kind == bgh_pkg::KIND_READ) && w_rd_ok;
            end
            ST_SUM: begin
                w_re    = 1'b1;
                w_raddr = w_pix_idx;
            end
            ST_INC: begin
                w_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    bgh_count_ram #(
        .DEPTH (bgh_pkg::NUM_COUNTERS),
        .WIDTH (bgh_pkg::COUNT_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_beat_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    if (r_clr_addr == bgh_pkg::IDX_W'(bgh_pkg::NUM_COUNTERS - 1)) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (w_acc) begin
                        case (i_in.kind)
                            bgh_pkg::KIND_PIXEL: begin
                                if (w_pos.in_grid) begin
                                    r_state <= ST_SUM;
                                end
                            end
                            bgh_pkg::KIND_READ: begin
                                r_rd_zero <= !w_rd_ok;
                                r_state   <= ST_RESULT;
                            end
                            bgh_pkg::KIND_CLEAR: begin
                                r_clr_addr <= '0;
                                r_state    <= ST_CLEAR;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SUM: begin
                    r_addr  <= w_pix_idx;
                    r_state <= ST_INC;
                end
                ST_INC: begin
                    r_state <= ST_IDLE;
                end
                ST_RESULT: begin
                    // hold the read data until the output register is free
                    if (w_out_free) begin
                        r_count <= r_rd_zero ? '0 : w_rdata;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.count = r_count;

`ifndef SYNTHESIS
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in.kind == bgh_pkg::KIND_CLEAR) |=> !i_in.ready)
        else $error("item accepted during counter clear");

    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && w_re))
        else $error("counter memory read and written in one cycle");

    a_wb_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INC) |-> (w_waddr == $past(w_raddr) && $past(w_re)))
        else $error("write-back to an entry other than the one read");
`endif

endmodule

>>> dv/bgh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgh_checker: scoreboard for the tiled gray histogram
// Watches the item, count and register channels, keeps its own copy of the
// grid counters and raster position, and compares every count beat in order.
// ----------------------------------------------------------------------------
module bgh_checker
    import bgh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    bgh_in_if    in_ch,
    bgh_out_if   out_ch,
    bgh_cfg_if   cfg_ch,
    output int   o_mismatches,
    output int   o_reads_open
);

    localparam int W_BLUE  = 1868;
    localparam int W_GREEN = 9617;
    localparam int W_RED   = 4899;
    localparam int W_HALF  = 8192;
    localparam int Q_SHIFT = 14;

    typedef struct packed {
        logic [IMG_W-1:0] col_pos;
        logic [BLK_W-1:0] col_in_blk;
        logic [4:0]       grid_col;
        logic [BLK_W-1:0] row_in_blk;
        logic [4:0]       grid_row;
    } raster_t;

    typedef struct packed {
        logic [3:0]         row;
        logic [3:0]         col;
        logic [3:0]         bin;
        logic [COUNT_W-1:0] count;
    } count_due_t;

    logic [IMG_W-1:0]   image_width;
    logic [BLK_W-1:0]   block_width;
    logic [BLK_W-1:0]   block_height;
    logic [COUNT_W-1:0] tally [NUM_COUNTERS];
    raster_t            at;
    count_due_t         counts_due [$];
    count_due_t         oldest;
    int                 n_errors = 0;

    task automatic flag_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        n_errors++;
    endtask

    function automatic int unsigned gray_bin(input logic [7:0] b, g, r);
        int unsigned gray;
        int unsigned bin;
        gray = (W_BLUE * int'(b) + W_GREEN * int'(g) + W_RED * int'(r) + W_HALF) >> Q_SHIFT;
        bin  = gray / (256 / BINS);
        if (bin > BINS - 1) bin = BINS - 1;
        return bin;
    endfunction

    function automatic int unsigned slot(input int unsigned row, col, bin);
        return (row * GRID_COLS + col) * BINS + bin;
    endfunction

    function automatic logic [COUNT_W-1:0] lookup(input logic [3:0] row, col, bin);
        if (row < GRID_ROWS && col < GRID_COLS && bin < BINS)
            return tally[slot(row, col, bin)];
        return '0;
    endfunction

    task automatic wipe();
        foreach (tally[i]) tally[i] = '0;
        at = '0;
    endtask

    task automatic take_pixel(input logic [7:0] b, g, r);
        int unsigned k;
        if (at.grid_row < GRID_ROWS && at.grid_col < GRID_COLS) begin
            k = slot(at.grid_row, at.grid_col, gray_bin(b, g, r));
            if (tally[k] != COUNT_MAX) tally[k] = tally[k] + 1'b1;
        end
        // advance the raster position; comparisons are reached-or-passed
        at.col_pos    = at.col_pos + 1'b1;
        at.col_in_blk = at.col_in_blk + 1'b1;
        if (at.col_in_blk >= block_width) begin
            at.col_in_blk = '0;
            if (at.grid_col < GRID_COLS) at.grid_col = at.grid_col + 1'b1;
        end
        if (at.col_pos >= image_width) begin
            at.col_pos    = '0;
            at.col_in_blk = '0;
            at.grid_col   = '0;
            at.row_in_blk = at.row_in_blk + 1'b1;
            if (at.row_in_blk >= block_height) begin
                at.row_in_blk = '0;
                if (at.grid_row < GRID_ROWS) at.grid_row = at.grid_row + 1'b1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            image_width  = RST_IMAGE_WIDTH;
            block_width  = RST_BLOCK_WIDTH;
            block_height = RST_BLOCK_HEIGHT;
            wipe();
            counts_due.delete();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_IMAGE_WIDTH:  image_width  = cfg_ch.data[IMG_W-1:0];
                    CFG_BLOCK_WIDTH:  block_width  = cfg_ch.data[BLK_W-1:0];
                    CFG_BLOCK_HEIGHT: block_height = cfg_ch.data[BLK_W-1:0];
                    default: ;
                endcase
            end
            // retire the count beat before queueing a new read from the same edge
            if (out_ch.valid && out_ch.ready) begin
                if (counts_due.size() == 0) begin
                    flag_mismatch($sformatf("count beat %0d with no read outstanding",
                                            out_ch.count));
                end else begin
                    oldest = counts_due.pop_front();
                    if (out_ch.count !== oldest.count)
                        flag_mismatch($sformatf("read row %0d col %0d bin %0d: count %0d, want %0d",
                                                oldest.row, oldest.col, oldest.bin,
                                                out_ch.count, oldest.count));
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                case (in_ch.kind)
                    KIND_PIXEL: take_pixel(in_ch.blue, in_ch.green, in_ch.red);
                    KIND_READ:  counts_due.push_back('{in_ch.read_block_row, in_ch.read_block_col,
                                                       in_ch.read_bin,
                                                       lookup(in_ch.read_block_row,
                                                              in_ch.read_block_col,
                                                              in_ch.read_bin)});
                    KIND_CLEAR: wipe();
                    default: ;
                endcase
            end
        end
        o_reads_open <= counts_due.size();
        o_mismatches <= n_errors;
    end

endmodule

>>> dv/block_gray_histogram_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_gray_histogram_tb: stimulus and verdict for the tiled gray histogram
// Directed pixels and reads at the field extremes, then random pixel streams
// with reads, clears and spare items over a series of block geometries.
// ----------------------------------------------------------------------------
module block_gray_histogram_tb;
    import bgh_pkg::*;

    localparam logic [1:0]           KIND_SPARE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;
    localparam int                   CYCLE_LIMIT  = 1_000_000;
    localparam int                   DRAIN_CYCLES = 1700;
    localparam int                   N_PHASES     = 10;
    localparam int                   RANDOM_ITEMS = 1430;

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   calm;
    bit   quiet;
    int   cycles = 0;
    int   mismatches;
    int   reads_open;
    int   n_pixels = 0;
    int   n_reads = 0;
    int   n_clears = 0;
    int   n_spare = 0;
    int   n_settings = 0;

    bgh_in_if  in_ch ();
    bgh_out_if out_ch ();
    bgh_cfg_if cfg_ch ();

    block_gray_histogram dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    bgh_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .o_mismatches (mismatches),
        .o_reads_open (reads_open)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reads still open", cycles, reads_open);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // switch between stretches with and without idling
    initial begin
        forever begin
            repeat ($urandom_range(50, 300)) @(posedge i_clk);
            calm <= ($urandom_range(0, 2) == 0);
        end
    end

    // count receiver: stall in bursts
    initial begin
        int hold;
        hold = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                hold--;
            end else begin
                out_ch.ready <= 1'b1;
                if (!calm && !quiet && $urandom_range(0, 9) == 0) hold = $urandom_range(1, 13);
            end
        end
    end

    task automatic put_item(input logic [1:0] kind, input logic [7:0] b, g, r,
                            input logic [3:0] row, col, bin);
        if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.kind           <= kind;
        in_ch.blue           <= b;
        in_ch.green          <= g;
        in_ch.red            <= r;
        in_ch.read_block_row <= row;
        in_ch.read_block_col <= col;
        in_ch.read_bin       <= bin;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        case (kind)
            KIND_PIXEL: n_pixels++;
            KIND_READ:  n_reads++;
            KIND_CLEAR: n_clears++;
            default:    n_spare++;
        endcase
    endtask

    // valid is left high so back-to-back register beats need no extra edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    task automatic set_geometry(input int iw, bw, bh);
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(iw));
        write_reg(CFG_BLOCK_WIDTH, CFG_DATA_W'(bw));
        write_reg(CFG_BLOCK_HEIGHT, CFG_DATA_W'(bh));
        cfg_ch.valid <= 1'b0;
        n_settings++;
    endtask

    // drain: every read answered, then room for a clear sweep to finish
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (reads_open != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_item();
        logic [7:0] b, g, r, v;
        logic [3:0] row, col, bin;
        int         pick;
        b    = $urandom_range(0, 255);
        g    = $urandom_range(0, 255);
        r    = $urandom_range(0, 255);
        row  = $urandom_range(0, 15);
        col  = $urandom_range(0, 15);
        bin  = $urandom_range(0, 15);
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
            case ($urandom_range(0, 3))
                2: begin
                    v = $urandom_range(0, 255);
                    b = v;
                    g = v;
                    r = v;
                end
                3: begin
                    b = {8{$urandom_range(0, 1) == 1}};
                    g = {8{$urandom_range(0, 1) == 1}};
                    r = {8{$urandom_range(0, 1) == 1}};
                end
                default: ;
            endcase
            put_item(KIND_PIXEL, b, g, r, row, col, bin);
        end else if (pick < 95) begin
            // favour the top-left blocks, where small geometries put most pixels
            case ($urandom_range(0, 9))
                0: ;
                1, 2, 3: begin
                    row = $urandom_range(0, GRID_ROWS - 1);
                    col = $urandom_range(0, GRID_COLS - 1);
                end
                default: begin
                    row = $urandom_range(0, 2);
                    col = $urandom_range(0, 2);
                end
            endcase
            put_item(KIND_READ, b, g, r, row, col, bin);
        end else if (pick < 98) begin
            put_item(KIND_SPARE, b, g, r, row, col, bin);
        end else begin
            put_item(KIND_CLEAR, b, g, r, row, col, bin);
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.kind   <= KIND_PIXEL;
        in_ch.blue   <= '0;
        in_ch.green  <= '0;
        in_ch.red    <= '0;
        in_ch.read_block_row <= '0;
        in_ch.read_block_col <= '0;
        in_ch.read_bin       <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_IMAGE_WIDTH;
        cfg_ch.data  <= '0;
        quiet        <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: all of these land in block 0,0
        put_item(KIND_PIXEL, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 4'h0);
        put_item(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 4'hF, 4'hF, 4'hF);
        put_item(KIND_PIXEL, 8'hFF, 8'h00, 8'h00, 4'h0, 4'h0, 4'h0);
        put_item(KIND_PIXEL, 8'h00, 8'hFF, 8'h00, 4'h0, 4'h0, 4'h0);
        put_item(KIND_PIXEL, 8'h00, 8'h00, 8'hFF, 4'h0, 4'h0, 4'h0);
        put_item(KIND_READ,  8'h00, 8'h00, 8'h00, 4'd0, 4'd0, 4'd0);
        put_item(KIND_READ,  8'hFF, 8'hFF, 8'hFF, 4'd0, 4'd0, 4'd15);
        put_item(KIND_READ,  8'h00, 8'h00, 8'h00, 4'd0, 4'd0, 4'd1);
        put_item(KIND_READ,  8'h00, 8'h00, 8'h00, 4'd0, 4'd0, 4'd4);
        put_item(KIND_READ,  8'h00, 8'h00, 8'h00, 4'd0, 4'd0, 4'd9);
        put_item(KIND_READ,  8'h00, 8'h00, 8'h00, 4'd9, 4'd9, 4'd15);
        // reads beyond the grid answer zero
        put_item(KIND_READ,  8'h00, 8'h00, 8'h00, 4'd10, 4'd0, 4'd0);
        put_item(KIND_READ,  8'h00, 8'h00, 8'h00, 4'd0, 4'd15, 4'd0);
        put_item(KIND_READ,  8'hFF, 8'hFF, 8'hFF, 4'd15, 4'd15, 4'd15);
        put_item(KIND_SPARE, 8'hFF, 8'hFF, 8'hFF, 4'hF, 4'hF, 4'hF);
        put_item(KIND_READ,  8'h00, 8'h00, 8'h00, 4'd0, 4'd0, 4'd15);
        put_item(KIND_CLEAR, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 4'h0);
        put_item(KIND_READ,  8'h00, 8'h00, 8'h00, 4'd0, 4'd0, 4'd15);

        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            if (p == N_PHASES - 1) quiet <= 1'b1;
            case (p)
                0: begin
                    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
                    set_geometry(12, 1, 1);
                end
                1: set_geometry(0, 0, 0);
                2: set_geometry(4095, 409, 409);
                3: set_geometry(23, 2, 1);
                4: set_geometry(1, 1, 409);
                5: set_geometry(4095, 1, 1);
                6: set_geometry(7, 409, 1);
                9: set_geometry(33, 3, 2);
                default: set_geometry($urandom_range(1, 60), $urandom_range(1, 8),
                                      $urandom_range(1, 4));
            endcase
            // without a clear the position carries over into the new geometry
            if ($urandom_range(0, 1) == 1)
                put_item(KIND_CLEAR, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 4'h0);
            repeat (RANDOM_ITEMS / N_PHASES) random_item();
        end
        settle();

        $display("Covered %0d pixels, %0d counter reads, %0d clears, %0d spare-kind items",
                 n_pixels, n_reads, n_clears, n_spare);
        $display("over %0d block geometries; %0d mismatches", n_settings, mismatches);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
